// File: rtl/core/dpif_pkg.sv
// Shared types, register codes and status helpers for the interprocessor link.
package dpif_pkg;

  // Parasite-to-host queue of channel 1
  localparam int UP_QUEUE_DEPTH = 24;
  localparam int UPQ_PTR_W = (UP_QUEUE_DEPTH > 1) ? $clog2(UP_QUEUE_DEPTH) : 1;
  localparam int UPQ_CNT_W = $clog2(UP_QUEUE_DEPTH + 1);

  // Access kinds
  localparam logic [1:0] ACT_READ       = 2'd0;
  localparam logic [1:0] ACT_WRITE      = 2'd1;
  localparam logic [1:0] ACT_TUBE_RESET = 2'd2;

  // Sides
  localparam logic SIDE_HOST = 1'b0;
  localparam logic SIDE_PAR  = 1'b1;

  // Register window
  localparam logic [2:0] ADDR_CTRL  = 3'd0;
  localparam logic [2:0] ADDR_DATA1 = 3'd1;
  localparam logic [2:0] ADDR_DATA2 = 3'd3;
  localparam logic [2:0] ADDR_DATA3 = 3'd5;
  localparam logic [2:0] ADDR_DATA4 = 3'd7;

  // Channel indexes into the status vector
  localparam logic [1:0] CH1 = 2'd0;
  localparam logic [1:0] CH2 = 2'd1;
  localparam logic [1:0] CH3 = 2'd2;
  localparam logic [1:0] CH4 = 2'd3;

  // Status bit kinds
  localparam logic SB_NOT_FULL = 1'b0;
  localparam logic SB_AVAIL    = 1'b1;

  // Control flag bit positions
  localparam int FLAG_Q = 0;
  localparam int FLAG_I = 1;
  localparam int FLAG_J = 2;
  localparam int FLAG_M = 3;
  localparam int FLAG_V = 4;

  localparam logic [7:0] DOWN_DUMMY       = 8'hE4;
  localparam logic [7:0] UP_DUMMY         = 8'h96;
  localparam logic [7:0] EMPTY_QUEUE_READ = 8'h01;
  localparam logic [7:0] CTRL_VISIBLE     = 8'h3F;
  localparam int         CTRL_SET_BIT     = 7;

  // All not-full bits set, host channel 3 available, parasite channel 3 not full clear
  localparam logic [15:0] STATUS_RESET = 16'h5355;

  typedef struct packed {
    logic [1:0] action;
    logic       side;
    logic [2:0] address;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       host_irq;
    logic       parasite_irq;
    logic       parasite_nmi;
  } out_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic [7:0] wdata;
  } upq_ctrl_t;

  typedef struct packed {
    logic [UPQ_CNT_W-1:0] count;
    logic [7:0]           head;
  } upq_stat_t;

  function automatic logic [3:0] st_pos(input logic [1:0] ch, input logic side,
                                        input logic which);
    return {ch, side, which};
  endfunction

  function automatic logic [7:0] st_byte(input logic [15:0] s, input logic [1:0] ch,
                                         input logic side);
    return {s[st_pos(ch, side, SB_AVAIL)], s[st_pos(ch, side, SB_NOT_FULL)], 6'b0};
  endfunction

  // Consume a latch word: free the writer side
  function automatic logic [15:0] latch_rd(input logic [15:0] s, input logic [1:0] ch,
                                           input logic side);
    logic [15:0] r;
    r = s;
    if (s[st_pos(ch, side, SB_AVAIL)]) begin
      r[st_pos(ch, side, SB_AVAIL)]     = 1'b0;
      r[st_pos(ch, ~side, SB_NOT_FULL)] = 1'b1;
    end
    return r;
  endfunction

  // Post a latch word: mark it available to the reader side
  function automatic logic [15:0] latch_wr(input logic [15:0] s, input logic [1:0] ch,
                                           input logic side);
    logic [15:0] r;
    r = s;
    r[st_pos(ch, side, SB_NOT_FULL)] = 1'b0;
    r[st_pos(ch, ~side, SB_AVAIL)]   = 1'b1;
    return r;
  endfunction

endpackage

// File: rtl/core/dpif_upq.sv
// Parasite-to-host word queue of channel 1.
module dpif_upq import dpif_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  upq_ctrl_t ctrl,
  output upq_stat_t stat
);

  logic [7:0]           mem_r [UP_QUEUE_DEPTH];
  logic [7:0]           head_r;
  logic [UPQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [UPQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [UPQ_CNT_W-1:0] count_r, count_nxt;

  function automatic logic [UPQ_PTR_W-1:0] ptr_inc(input logic [UPQ_PTR_W-1:0] p);
    return (p == UPQ_PTR_W'(UP_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctrl.flush) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      count_nxt  = '0;
    end else if (ctrl.push) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      count_nxt  = count_r + 1'b1;
    end else if (ctrl.pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage and head carry no reset; the head is only used while words are queued.
  // Fetch the head word for the next read pointer; a push into an empty queue
  // bypasses straight into the head register.
  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.flush) begin
      mem_r[wr_ptr_r] <= ctrl.wdata;
    end
    if (ctrl.push && !ctrl.flush && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= ctrl.wdata;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign stat.count = count_r;
  assign stat.head  = head_r;

endmodule

// File: rtl/core/dpif_link.sv
// Register decode, channel latches, channel 3 buffers, status and interrupt lines.
module dpif_link import dpif_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  upq_stat_t q_stat,
  output upq_ctrl_t q_ctrl,
  output out_item_t result
);

  logic [7:0]      flags_r, flags_nxt;
  logic [15:0]     status_r, status_nxt;
  logic [15:0]     status_view;
  logic [7:0]      dl1_r, dl1_nxt;
  logic [1:0][7:0] c2_r, c2_nxt;
  logic [1:0][7:0] c4_r, c4_nxt;
  logic [1:0][7:0] dn_pair_r, dn_pair_nxt;
  logic [1:0][7:0] up_pair_r, up_pair_nxt;
  logic [1:0]      dn_cnt_r, dn_cnt_nxt;
  logic [1:0]      up_cnt_r, up_cnt_nxt;
  logic [7:0]      rd;
  logic            q_empty, q_full;

  function automatic logic nmi_cond(input logic v, input logic [1:0] dn, input logic [1:0] up);
    return v ? ((dn == 2'd2) || (up == 2'd0)) : ((dn != 2'd0) || (up == 2'd0));
  endfunction

  always_comb begin
    flags_nxt   = flags_r;
    status_nxt  = status_r;
    dl1_nxt     = dl1_r;
    c2_nxt      = c2_r;
    c4_nxt      = c4_r;
    dn_pair_nxt = dn_pair_r;
    up_pair_nxt = up_pair_r;
    dn_cnt_nxt  = dn_cnt_r;
    up_cnt_nxt  = up_cnt_r;
    rd          = '0;
    q_ctrl      = '0;
    q_ctrl.wdata = item.write_data;

    q_empty = (q_stat.count == '0);
    q_full  = (q_stat.count == UPQ_CNT_W'(UP_QUEUE_DEPTH));

    // Queue status and the parasite channel 3 available bit follow live state
    status_view = status_r;
    status_view[st_pos(CH1, SIDE_HOST, SB_AVAIL)]   = !q_empty;
    status_view[st_pos(CH1, SIDE_PAR, SB_NOT_FULL)] = !q_full;
    status_view[st_pos(CH3, SIDE_PAR, SB_AVAIL)]    =
      nmi_cond(flags_r[FLAG_V], dn_cnt_r, up_cnt_r);

    if (fire) begin
      case (item.action)
        ACT_TUBE_RESET: begin
          q_ctrl.flush = 1'b1;
          status_nxt   = STATUS_RESET;
          dl1_nxt      = '0;
          c2_nxt       = '0;
          c4_nxt       = '0;
          dn_pair_nxt  = {2{DOWN_DUMMY}};
          up_pair_nxt  = {2{UP_DUMMY}};
          dn_cnt_nxt   = 2'd0;
          up_cnt_nxt   = 2'd1;
        end
        ACT_READ: begin
          if (!item.address[0]) begin
            rd = st_byte(status_view, item.address[2:1], item.side);
            if (item.address == ADDR_CTRL) begin
              rd = rd | (flags_r & CTRL_VISIBLE);
            end
          end else if (item.side == SIDE_HOST) begin
            unique case (item.address)
              ADDR_DATA1: begin
                if (q_empty) begin
                  rd = EMPTY_QUEUE_READ;
                end else begin
                  rd = q_stat.head;
                  q_ctrl.pop = 1'b1;
                end
              end
              ADDR_DATA2: begin
                status_nxt = latch_rd(status_r, CH2, SIDE_HOST);
                rd = c2_r[1];
              end
              ADDR_DATA3: begin
                if (up_cnt_r != 2'd0) begin
                  rd = up_pair_r[0];
                  up_pair_nxt[0] = up_pair_r[1];
                  up_cnt_nxt = up_cnt_r - 2'd1;
                end else begin
                  rd = UP_DUMMY;
                end
                if (up_cnt_nxt == 2'd0) begin
                  status_nxt[st_pos(CH3, SIDE_HOST, SB_AVAIL)]   = 1'b0;
                  status_nxt[st_pos(CH3, SIDE_PAR, SB_NOT_FULL)] = 1'b1;
                end
              end
              default: begin
                status_nxt = latch_rd(status_r, CH4, SIDE_HOST);
                rd = c4_r[1];
              end
            endcase
          end else begin
            unique case (item.address)
              ADDR_DATA1: begin
                status_nxt = latch_rd(status_r, CH1, SIDE_PAR);
                rd = dl1_r;
              end
              ADDR_DATA2: begin
                status_nxt = latch_rd(status_r, CH2, SIDE_PAR);
                rd = c2_r[0];
              end
              ADDR_DATA3: begin
                if (dn_cnt_r != 2'd0) begin
                  rd = dn_pair_r[0];
                  dn_pair_nxt[0] = dn_pair_r[1];
                  dn_cnt_nxt = dn_cnt_r - 2'd1;
                end else begin
                  rd = DOWN_DUMMY;
                end
                if (dn_cnt_nxt == 2'd0) begin
                  status_nxt[st_pos(CH3, SIDE_PAR, SB_AVAIL)]     = 1'b0;
                  status_nxt[st_pos(CH3, SIDE_HOST, SB_NOT_FULL)] = 1'b1;
                end
              end
              default: begin
                status_nxt = latch_rd(status_r, CH4, SIDE_PAR);
                rd = c4_r[0];
              end
            endcase
          end
        end
        ACT_WRITE: begin
          if (item.side == SIDE_HOST) begin
            unique case (item.address)
              ADDR_CTRL: begin
                if (item.write_data[CTRL_SET_BIT]) begin
                  flags_nxt = flags_r | item.write_data;
                end else begin
                  flags_nxt = flags_r & ~item.write_data;
                end
              end
              ADDR_DATA1: begin
                dl1_nxt = item.write_data;
                status_nxt = latch_wr(status_r, CH1, SIDE_HOST);
              end
              ADDR_DATA2: begin
                c2_nxt[0] = item.write_data;
                status_nxt = latch_wr(status_r, CH2, SIDE_HOST);
              end
              ADDR_DATA3: begin
                // A full buffer drops the word but still updates status
                if (dn_cnt_r < 2'd2) begin
                  dn_pair_nxt[dn_cnt_r[0]] = item.write_data;
                  dn_cnt_nxt = dn_cnt_r + 2'd1;
                end
                if (!flags_r[FLAG_V] || (dn_cnt_nxt == 2'd2)) begin
                  status_nxt = latch_wr(status_r, CH3, SIDE_HOST);
                end
              end
              ADDR_DATA4: begin
                c4_nxt[0] = item.write_data;
                status_nxt = latch_wr(status_r, CH4, SIDE_HOST);
              end
              default: begin
              end
            endcase
          end else begin
            unique case (item.address)
              ADDR_DATA1: begin
                q_ctrl.push = !q_full;
              end
              ADDR_DATA2: begin
                c2_nxt[1] = item.write_data;
                status_nxt = latch_wr(status_r, CH2, SIDE_PAR);
              end
              ADDR_DATA3: begin
                if (up_cnt_r < 2'd2) begin
                  up_pair_nxt[up_cnt_r[0]] = item.write_data;
                  up_cnt_nxt = up_cnt_r + 2'd1;
                end
                if (!flags_r[FLAG_V] || (up_cnt_nxt == 2'd2)) begin
                  status_nxt = latch_wr(status_r, CH3, SIDE_PAR);
                end
              end
              ADDR_DATA4: begin
                c4_nxt[1] = item.write_data;
                status_nxt = latch_wr(status_r, CH4, SIDE_PAR);
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    // Interrupt lines from the state after the access
    result.read_data    = rd;
    result.host_irq     = flags_nxt[FLAG_Q] & status_nxt[st_pos(CH4, SIDE_HOST, SB_AVAIL)];
    result.parasite_irq = (flags_nxt[FLAG_I] & status_nxt[st_pos(CH1, SIDE_PAR, SB_AVAIL)]) |
                          (flags_nxt[FLAG_J] & status_nxt[st_pos(CH4, SIDE_PAR, SB_AVAIL)]);
    result.parasite_nmi = flags_nxt[FLAG_M] &
                          nmi_cond(flags_nxt[FLAG_V], dn_cnt_nxt, up_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      status_r  <= STATUS_RESET;
      dl1_r     <= '0;
      c2_r      <= '0;
      c4_r      <= '0;
      dn_pair_r <= {2{DOWN_DUMMY}};
      up_pair_r <= {2{UP_DUMMY}};
      dn_cnt_r  <= 2'd0;
      up_cnt_r  <= 2'd1;
    end else begin
      flags_r   <= flags_nxt;
      status_r  <= status_nxt;
      dl1_r     <= dl1_nxt;
      c2_r      <= c2_nxt;
      c4_r      <= c4_nxt;
      dn_pair_r <= dn_pair_nxt;
      up_pair_r <= up_pair_nxt;
      dn_cnt_r  <= dn_cnt_nxt;
      up_cnt_r  <= up_cnt_nxt;
    end
  end

endmodule

// File: rtl/core/dual_port_interprocessor_fifo_ula_core.sv
// Top level of the host/parasite interprocessor link: input reg, access logic, result reg.
//
//   channel | ports                          | word
//   --------+--------------------------------+-----------------------------------------
//   access  | in_valid, in_stall, in_item    | action, side, address, write_data
//   result  | out_valid, out_stall, out_item | read_data, host_irq, parasite_irq,
//           |                                |   parasite_nmi
//
// One access word is taken every cycle while in_stall is low; its result is loaded
// into the result register when the word executes and is handed over from there.
// The single pass of access logic sits between the input and result registers.
// Reset is synchronous on rst_n low and loads the same state as a tube reset,
// with the control flags cleared as well.
// A stalled result holds in the result register while the input register keeps
// taking one more word; in_stall rises only when both are full.
module dual_port_interprocessor_fifo_ula_core import dpif_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      in_full_r, in_full_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      out_adv;
  logic      fire;
  logic      in_take;
  upq_ctrl_t q_ctrl;
  upq_stat_t q_stat;
  out_item_t result;

  // Result register can load when empty or being drained this cycle
  assign out_adv  = !out_valid_r || !out_stall;
  // The buffered word executes and moves to the result register
  assign fire     = in_full_r && out_adv;
  assign in_stall = in_full_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (fire) begin
      in_full_nxt = 1'b0;
    end
    out_valid_nxt = out_adv ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: input loads on take, result loads on fire, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  dpif_link u_link (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .q_stat (q_stat),
    .q_ctrl (q_ctrl),
    .result (result)
  );

  dpif_upq u_upq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A buffered word that has not executed stays put
  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && !fire |=> in_full_r && $stable(in_item_r))
    else $error("pending access word lost or changed");

  // Queue never holds more words than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= UPQ_CNT_W'(UP_QUEUE_DEPTH))
    else $error("up queue count beyond depth");

  // Tube reset empties the queue and returns a zero byte
  a_tube_reset: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_item_r.action == ACT_TUBE_RESET)
    |=> out_valid_r && (out_item_r.read_data == 8'h00) && (q_stat.count == '0))
    else $error("tube reset did not clear link state");

  // Host read of an empty queue returns the empty marker
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_item_r.action == ACT_READ) && (in_item_r.side == SIDE_HOST) &&
    (in_item_r.address == ADDR_DATA1) && (q_stat.count == '0)
    |=> out_item_r.read_data == EMPTY_QUEUE_READ)
    else $error("empty queue read returned wrong byte");

endmodule

// File: bench/dual_port_interprocessor_fifo_ula_core_test.sv
// Self-checking bench for the interprocessor link core: random register accesses checked against a link model.
`timescale 1ns / 1ps

import dpif_pkg::*;

class link_scoreboard;
  logic [7:0]  flags;
  logic [7:0]  upq [UP_QUEUE_DEPTH];
  int          upq_wr;
  int          upq_rd;
  int          upq_cnt;
  logic [7:0]  down1;
  logic [7:0]  ch2 [2];       // [0] host to parasite, [1] parasite to host
  logic [7:0]  ch4 [2];
  logic [7:0]  pair3 [2][2];  // [0] down pair, [1] up pair
  int          pair3_n [2];
  logic [15:0] status;
  logic [2:0]  irq_lines;     // {nmi, pirq, hirq}
  out_item_t   pending_replies[$];
  int          errors;

  function new();
    flags  = '0;
    errors = 0;
    clear_link();
    refresh_lines();
  endfunction

  function int bitpos(int ch, int side, int which);
    return ch * 4 + side * 2 + which;
  endfunction

  function bit get_st(int ch, int side, int which);
    return status[bitpos(ch, side, which)];
  endfunction

  function void set_st(int ch, int side, int which, bit v);
    status[bitpos(ch, side, which)] = v;
  endfunction

  function void take_latch(int ch, int side);
    if (get_st(ch, side, SB_AVAIL)) begin
      set_st(ch, side, SB_AVAIL, 1'b0);
      set_st(ch, side ^ 1, SB_NOT_FULL, 1'b1);
    end
  endfunction

  function void post_latch(int ch, int side);
    set_st(ch, side, SB_NOT_FULL, 1'b0);
    set_st(ch, side ^ 1, SB_AVAIL, 1'b1);
  endfunction

  // Tube reset: everything but the control flags
  function void clear_link();
    upq_wr     = 0;
    upq_rd     = 0;
    upq_cnt    = 0;
    down1      = '0;
    ch2[0]     = '0;
    ch2[1]     = '0;
    ch4[0]     = '0;
    ch4[1]     = '0;
    pair3[0][0] = DOWN_DUMMY;
    pair3[0][1] = DOWN_DUMMY;
    pair3[1][0] = UP_DUMMY;
    pair3[1][1] = UP_DUMMY;
    pair3_n[0] = 0;
    pair3_n[1] = 1;
    status     = '0;
    for (int ch = 0; ch < 4; ch++) begin
      set_st(ch, SIDE_HOST, SB_NOT_FULL, 1'b1);
      set_st(ch, SIDE_PAR, SB_NOT_FULL, 1'b1);
    end
    set_st(CH3, SIDE_HOST, SB_AVAIL, 1'b1);
    set_st(CH3, SIDE_PAR, SB_NOT_FULL, 1'b0);
  endfunction

  function void refresh_lines();
    bit cond;
    bit hirq;
    bit pirq;
    if (flags[FLAG_V])
      cond = (pair3_n[0] == 2) || (pair3_n[1] == 0);
    else
      cond = (pair3_n[0] > 0) || (pair3_n[1] == 0);
    set_st(CH3, SIDE_PAR, SB_AVAIL, cond);
    hirq = flags[FLAG_Q] && get_st(CH4, SIDE_HOST, SB_AVAIL);
    pirq = (flags[FLAG_I] && get_st(CH1, SIDE_PAR, SB_AVAIL)) ||
           (flags[FLAG_J] && get_st(CH4, SIDE_PAR, SB_AVAIL));
    irq_lines = {cond && flags[FLAG_M], pirq, hirq};
  endfunction

  function logic [7:0] pair_pop(int dir, int side);
    logic [7:0] v;
    if (pair3_n[dir] > 0) begin
      v = pair3[dir][0];
      pair3[dir][0] = pair3[dir][1];
      pair3_n[dir]--;
    end else begin
      v = dir ? UP_DUMMY : DOWN_DUMMY;
    end
    if (pair3_n[dir] == 0) begin
      set_st(CH3, side, SB_AVAIL, 1'b0);
      set_st(CH3, side ^ 1, SB_NOT_FULL, 1'b1);
    end
    return v;
  endfunction

  // A third byte is dropped but the status still moves
  function void pair_push(int dir, int side, logic [7:0] v);
    if (pair3_n[dir] < 2) begin
      pair3[dir][pair3_n[dir]] = v;
      pair3_n[dir]++;
    end
    if (flags[FLAG_V]) begin
      if (pair3_n[dir] == 2) begin
        set_st(CH3, side, SB_NOT_FULL, 1'b0);
        set_st(CH3, side ^ 1, SB_AVAIL, 1'b1);
      end
    end else begin
      post_latch(CH3, side);
    end
  endfunction

  function logic [7:0] queue_pop();
    logic [7:0] v;
    if (upq_cnt == 0) return EMPTY_QUEUE_READ;
    v = upq[upq_rd];
    upq_rd = (upq_rd + 1 == UP_QUEUE_DEPTH) ? 0 : upq_rd + 1;
    upq_cnt--;
    set_st(CH1, SIDE_PAR, SB_NOT_FULL, 1'b1);
    if (upq_cnt == 0) set_st(CH1, SIDE_HOST, SB_AVAIL, 1'b0);
    return v;
  endfunction

  function void queue_push(logic [7:0] v);
    if (upq_cnt >= UP_QUEUE_DEPTH) return;
    upq[upq_wr] = v;
    upq_wr = (upq_wr + 1 == UP_QUEUE_DEPTH) ? 0 : upq_wr + 1;
    upq_cnt++;
    if (upq_cnt == UP_QUEUE_DEPTH) set_st(CH1, SIDE_PAR, SB_NOT_FULL, 1'b0);
    set_st(CH1, SIDE_HOST, SB_AVAIL, 1'b1);
  endfunction

  function void note_access(in_item_t w);
    logic [7:0] rd;
    int         side;
    int         ch;
    out_item_t  e;
    rd   = '0;
    side = int'(w.side);
    ch   = int'(w.address[2:1]);
    case (w.action)
      ACT_TUBE_RESET: clear_link();
      ACT_READ: begin
        if (!w.address[0]) begin
          rd = {get_st(ch, side, SB_AVAIL), get_st(ch, side, SB_NOT_FULL), 6'b0};
          if (w.address == ADDR_CTRL) rd = rd | (flags & CTRL_VISIBLE);
        end else if (w.side == SIDE_HOST) begin
          case (w.address)
            ADDR_DATA1: rd = queue_pop();
            ADDR_DATA2: begin
              take_latch(CH2, SIDE_HOST);
              rd = ch2[1];
            end
            ADDR_DATA3: rd = pair_pop(1, SIDE_HOST);
            default: begin
              take_latch(CH4, SIDE_HOST);
              rd = ch4[1];
            end
          endcase
        end else begin
          case (w.address)
            ADDR_DATA1: begin
              take_latch(CH1, SIDE_PAR);
              rd = down1;
            end
            ADDR_DATA2: begin
              take_latch(CH2, SIDE_PAR);
              rd = ch2[0];
            end
            ADDR_DATA3: rd = pair_pop(0, SIDE_PAR);
            default: begin
              take_latch(CH4, SIDE_PAR);
              rd = ch4[0];
            end
          endcase
        end
      end
      ACT_WRITE: begin
        if (w.side == SIDE_HOST) begin
          case (w.address)
            ADDR_CTRL: begin
              if (w.write_data[CTRL_SET_BIT]) flags = flags | w.write_data;
              else flags = flags & ~w.write_data;
            end
            ADDR_DATA1: begin
              down1 = w.write_data;
              post_latch(CH1, SIDE_HOST);
            end
            ADDR_DATA2: begin
              ch2[0] = w.write_data;
              post_latch(CH2, SIDE_HOST);
            end
            ADDR_DATA3: pair_push(0, SIDE_HOST, w.write_data);
            ADDR_DATA4: begin
              ch4[0] = w.write_data;
              post_latch(CH4, SIDE_HOST);
            end
            default: ;
          endcase
        end else begin
          case (w.address)
            ADDR_DATA1: queue_push(w.write_data);
            ADDR_DATA2: begin
              ch2[1] = w.write_data;
              post_latch(CH2, SIDE_PAR);
            end
            ADDR_DATA3: pair_push(1, SIDE_PAR, w.write_data);
            ADDR_DATA4: begin
              ch4[1] = w.write_data;
              post_latch(CH4, SIDE_PAR);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    refresh_lines();
    e.read_data    = rd;
    e.host_irq     = irq_lines[0];
    e.parasite_irq = irq_lines[1];
    e.parasite_nmi = irq_lines[2];
    pending_replies.push_back(e);
  endfunction

  function void check_reply(out_item_t got);
    out_item_t want;
    if (pending_replies.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected, expected none got %h", $time, got);
      return;
    end
    want = pending_replies.pop_front();
    if (got.read_data !== want.read_data) begin
      errors++;
      $display("%0t: read_data expected %h got %h", $time, want.read_data, got.read_data);
    end
    if (got.host_irq !== want.host_irq) begin
      errors++;
      $display("%0t: host_irq expected %b got %b", $time, want.host_irq, got.host_irq);
    end
    if (got.parasite_irq !== want.parasite_irq) begin
      errors++;
      $display("%0t: parasite_irq expected %b got %b", $time,
               want.parasite_irq, got.parasite_irq);
    end
    if (got.parasite_nmi !== want.parasite_nmi) begin
      errors++;
      $display("%0t: parasite_nmi expected %b got %b", $time,
               want.parasite_nmi, got.parasite_nmi);
    end
  endfunction
endclass

module dual_port_interprocessor_fifo_ula_core_test;

  localparam int         HALF_PERIOD   = 10;
  localparam int         RESET_CYCLES  = 8;
  localparam int         TARGET_WORDS  = 1030;  // directed plus random, ignored words excluded
  localparam int         TAIL_WORDS    = 880;   // no sender gaps past this word count
  localparam int         TAIL_RESULTS  = 880;   // no receiver stalls past this result count
  localparam int         DRAIN_AT      = 500;   // sender waits for an empty pipe here
  localparam int         LONG_HOLD_AT  = 300;   // receiver holds off once after this many results
  localparam int         LONG_HOLD     = 64;
  localparam int         DRAIN_CYCLES  = 10;
  localparam logic [1:0] ACT_NOP       = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  link_scoreboard board;
  int             offered_words;

  dual_port_interprocessor_fifo_ula_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watch both handshakes at the edge where the block itself samples them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_access(in_item);
      if (out_valid && !out_stall) board.check_reply(out_item);
    end
  end

  function automatic in_item_t acc(logic [1:0] a, logic s, logic [2:0] ad, logic [7:0] d);
    in_item_t w;
    w.action     = a;
    w.side       = s;
    w.address    = ad;
    w.write_data = d;
    return w;
  endfunction

  // Present a word and hold it until the block takes it.
  task automatic send_access(input in_item_t w);
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Drop valid while the sender pauses.
  task automatic sender_pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Insert a random gap now and then, send, and count words that do something.
  task automatic offer(input in_item_t w);
    if (offered_words < TAIL_WORDS && $urandom_range(0, 9) == 0)
      sender_pause($urandom_range(1, 19));
    send_access(w);
    if (!(w.action == ACT_NOP ||
          (w.action == ACT_WRITE && !w.address[0] &&
           !(w.side == SIDE_HOST && w.address == ADDR_CTRL))))
      offered_words++;
  endtask

  // Receiver: random stall bursts, one long hold-off, quiet tail.
  initial begin
    int  rx_seen;
    bit  held_long;
    rx_seen   = 0;
    held_long = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) rx_seen++;
      if (!held_long && rx_seen >= LONG_HOLD_AT) begin
        // Hold long enough that both pipeline registers fill and in_stall rises.
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_seen < TAIL_RESULTS && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Sender: reset, directed words, then random sequences, then drain and judge.
  initial begin
    int         pick;
    int         n;
    int         m;
    int         act;
    bit         drained;
    logic       wside;
    logic [2:0] reg_addr;
    logic [1:0] a;
    board         = new();
    offered_words = 0;
    drained       = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset contents, empty reads, channel 1 both ways, writes to channels
    // 2 to 4, overflow of the channel-3 pair, ignored writes, no-op and tube reset.
    offer(acc(ACT_READ, SIDE_HOST, ADDR_CTRL, 8'h00));
    offer(acc(ACT_READ, SIDE_HOST, ADDR_DATA1, 8'h00));   // empty queue
    offer(acc(ACT_READ, SIDE_HOST, ADDR_DATA3, 8'h00));   // preset byte
    offer(acc(ACT_READ, SIDE_HOST, ADDR_DATA3, 8'h00));   // dummy byte
    offer(acc(ACT_READ, SIDE_PAR, ADDR_DATA3, 8'h00));    // dummy byte
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_CTRL, 8'hFF));   // set every flag
    offer(acc(ACT_READ, SIDE_PAR, ADDR_CTRL, 8'h00));
    offer(acc(ACT_WRITE, SIDE_PAR, ADDR_DATA1, 8'hFF));
    offer(acc(ACT_READ, SIDE_HOST, ADDR_DATA1, 8'h00));
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_DATA1, 8'h00));
    offer(acc(ACT_READ, SIDE_PAR, ADDR_DATA1, 8'h00));
    offer(acc(ACT_READ, SIDE_PAR, ADDR_DATA1, 8'h00));    // latch not available
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_DATA2, 8'hA5));
    offer(acc(ACT_WRITE, SIDE_PAR, ADDR_DATA4, 8'h5A));
    offer(acc(ACT_READ, SIDE_HOST, ADDR_DATA4, 8'h00));
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_DATA3, 8'h11));
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_DATA3, 8'h22));
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_DATA3, 8'h33));  // pair full, byte dropped
    offer(acc(ACT_READ, SIDE_PAR, ADDR_DATA3, 8'h00));
    offer(acc(ACT_READ, SIDE_PAR, ADDR_DATA3, 8'h00));
    offer(acc(ACT_READ, SIDE_PAR, ADDR_DATA3, 8'h00));
    offer(acc(ACT_WRITE, SIDE_PAR, ADDR_CTRL, 8'hFF));    // ignored
    offer(acc(ACT_WRITE, SIDE_HOST, 3'd6, 8'h55));        // ignored
    offer(acc(ACT_NOP, SIDE_PAR, 3'd7, 8'hAA));
    offer(acc(ACT_TUBE_RESET, SIDE_HOST, ADDR_CTRL, 8'h00));
    offer(acc(ACT_READ, SIDE_HOST, ADDR_CTRL, 8'h00));    // flags survive
    offer(acc(ACT_WRITE, SIDE_HOST, ADDR_CTRL, 8'h7F));   // clear them

    while (offered_words < TARGET_WORDS) begin
      if (!drained && offered_words >= DRAIN_AT) begin
        // Stop offering until every outstanding result is back.
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_replies.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // Noise: any action, side, address and data.
        n = $urandom_range(1, 4);
        repeat (n) begin
          act = $urandom_range(0, 19);
          a = (act < 9) ? ACT_READ : (act < 18) ? ACT_WRITE :
              (act == 18) ? ACT_TUBE_RESET : ACT_NOP;
          offer(acc(a, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255))));
        end
      end else if (pick < 32) begin
        // Fill the up queue, sometimes past full, then drain it, sometimes past empty.
        n = $urandom_range(1, 28);
        repeat (n) begin
          offer(acc(ACT_WRITE, SIDE_PAR, ADDR_DATA1, 8'($urandom_range(0, 255))));
          if ($urandom_range(0, 5) == 0) offer(acc(ACT_READ, SIDE_PAR, ADDR_CTRL, 8'h00));
        end
        m = $urandom_range(1, n + 2);
        repeat (m) begin
          offer(acc(ACT_READ, SIDE_HOST, ADDR_DATA1, 8'h00));
          if ($urandom_range(0, 5) == 0) offer(acc(ACT_READ, SIDE_HOST, ADDR_CTRL, 8'h00));
        end
      end else if (pick < 57) begin
        // Latch exchange on channel 1 down, 2 or 4.
        act = $urandom_range(0, 2);
        reg_addr = (act == 0) ? ADDR_DATA1 : (act == 1) ? ADDR_DATA2 : ADDR_DATA4;
        wside = (act == 0) ? SIDE_HOST : 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 2))
          offer(acc(ACT_WRITE, wside, reg_addr, 8'($urandom_range(0, 255))));
        offer(acc(ACT_READ, wside, reg_addr - 3'd1, 8'h00));
        offer(acc(ACT_READ, ~wside, reg_addr - 3'd1, 8'h00));
        repeat ($urandom_range(1, 2))
          offer(acc(ACT_READ, ~wside, reg_addr, 8'h00));
        offer(acc(ACT_READ, wside, reg_addr - 3'd1, 8'h00));
      end else if (pick < 77) begin
        // Channel-3 pair: up to three writes, up to four reads.
        wside = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 3))
          offer(acc(ACT_WRITE, wside, ADDR_DATA3, 8'($urandom_range(0, 255))));
        offer(acc(ACT_READ, ~wside, 3'd4, 8'h00));
        repeat ($urandom_range(1, 4)) begin
          offer(acc(ACT_READ, ~wside, ADDR_DATA3, 8'h00));
          if ($urandom_range(0, 2) == 0) offer(acc(ACT_READ, wside, 3'd4, 8'h00));
        end
      end else if (pick < 90) begin
        // Set or clear control flags, then look at status from either side.
        offer(acc(ACT_WRITE, SIDE_HOST, ADDR_CTRL, 8'($urandom_range(0, 255))));
        offer(acc(ACT_READ, 1'($urandom_range(0, 1)), ADDR_CTRL, 8'h00));
      end else if (pick < 93) begin
        offer(acc(ACT_TUBE_RESET, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255))));
      end else begin
        // Broken exchange: data accesses from random sides, sometimes cut by a reset.
        n = $urandom_range(2, 5);
        repeat (n) begin
          a = ($urandom_range(0, 1) == 1) ? ACT_WRITE : ACT_READ;
          if ($urandom_range(0, 9) == 0) a = ACT_TUBE_RESET;
          offer(acc(a, 1'($urandom_range(0, 1)), {2'($urandom_range(0, 3)), 1'b1},
                    8'($urandom_range(0, 255))));
        end
      end
    end

    // Drain, let the pipeline settle, then judge.
    in_valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dpif_pkg.sv
rtl/core/dpif_upq.sv
rtl/core/dpif_link.sv
rtl/core/dual_port_interprocessor_fifo_ula_core.sv
bench/dual_port_interprocessor_fifo_ula_core_test.sv
